>>> hw/rtl/rbts_pkg.sv
// shared types and constants for the bcd rtc snapshot to timestamp converter
// no dependencies; used by the interfaces, the datapath and the top level
package rbts_pkg;

  localparam int NSTAGE = 5;

  typedef logic [NSTAGE-1:0] stage_en_t;
  typedef logic signed [32:0] epoch_t;
  typedef logic signed [9:0] mon_ofs_t;

  localparam logic [7:0] HALT_BIT_MASK = 8'h80;
  localparam logic [7:0] SEC_MASK      = 8'h7f;
  localparam logic [7:0] MIN_MASK      = 8'h7f;
  localparam logic [7:0] HOUR_MASK     = 8'h3f;
  localparam logic [7:0] DATE_MASK     = 8'h3f;
  localparam logic [7:0] MONTH_MASK    = 8'h1f;

  localparam logic [4:0] FAT_HOUR_MAX  = 5'd23;
  localparam logic [6:0] FAT_MIN_MAX   = 7'd59;
  localparam logic [6:0] FAT_SEC_MAX   = 7'd59;
  localparam logic [6:0] FAT_SEC_OVER  = 7'd60;
  localparam logic [5:0] FAT_DAY_MAX   = 6'd31;
  localparam logic [4:0] FAT_MON_MAX   = 5'd12;
  localparam logic [7:0] FAT_YEAR_OFS  = 8'd20;
  localparam logic [7:0] FAT_YEAR_MAX  = 8'd119;

  localparam logic [7:0] CENTURY_SPLIT = 8'd70;
  localparam logic [7:0] CENTURY_ADD   = 8'd100;
  localparam logic [17:0] DAYS_4Y      = 18'd1461;
  // whole days up to the start of year 69 (march based), floor(1461*69/4)
  localparam logic signed [17:0] DAYS_BASE = 18'sd25202;
  localparam logic [17:0] SEC_PER_HOUR = 18'd3600;
  localparam logic [17:0] SEC_PER_MIN  = 18'd60;
  localparam logic signed [33:0] SEC_PER_DAY = 34'sd86400;

  // day offsets of a march based year, relative to the first entry
  localparam mon_ofs_t MONTH_OFS [12] = '{
    10'sd0,    10'sd31,   -10'sd306, -10'sd275, -10'sd245, -10'sd214,
    -10'sd184, -10'sd153, -10'sd122, -10'sd92,  -10'sd61,  -10'sd31
  };

  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'b0, b[7:4]};
    return 8'((tens << 3) + (tens << 1) + {4'b0, b[3:0]});
  endfunction

endpackage

>>> hw/rtl/rbts_ifs.sv
// valid/ready channel interfaces: clock snapshot in, timestamp result out
// depends on rbts_pkg
interface rbts_snap_if;
  logic       valid;
  logic       ready;
  logic [7:0] seconds_reg;
  logic [7:0] minutes_reg;
  logic [7:0] hours_reg;
  logic [7:0] date_reg;
  logic [7:0] month_reg;
  logic [7:0] year_reg;

  modport source (output valid, seconds_reg, minutes_reg, hours_reg, date_reg,
                  month_reg, year_reg, input ready);
  modport sink (input valid, seconds_reg, minutes_reg, hours_reg, date_reg,
                month_reg, year_reg, output ready);
endinterface

interface rbts_stamp_if;
  logic           valid;
  logic           ready;
  logic           status;
  logic [15:0]    fat_time;
  logic [15:0]    fat_date;
  rbts_pkg::epoch_t epoch_seconds;

  modport source (output valid, status, fat_time, fat_date, epoch_seconds,
                  input ready);
  modport sink (input valid, status, fat_time, fat_date, epoch_seconds,
                output ready);
endinterface

>>> hw/rtl/rbts_datapath.sv
// five register stages of payload: bcd decode, fat packing and day count,
// epoch day sum, day to seconds multiply, final add; depends on rbts_pkg
module rbts_datapath (
  input  logic                clk,
  input  rbts_pkg::stage_en_t en,
  input  logic [7:0]          seconds_reg,
  input  logic [7:0]          minutes_reg,
  input  logic [7:0]          hours_reg,
  input  logic [7:0]          date_reg,
  input  logic [7:0]          month_reg,
  input  logic [7:0]          year_reg,
  output logic                status,
  output logic [15:0]         fat_time,
  output logic [15:0]         fat_date,
  output rbts_pkg::epoch_t    epoch_seconds
);
  import rbts_pkg::*;

  // stage 1: decoded fields
  logic       s1_halt;
  logic [6:0] s1_sec, s1_min;
  logic [5:0] s1_hour, s1_day;
  logic [4:0] s1_mon;
  logic [7:0] s1_yr;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_halt <= (seconds_reg & HALT_BIT_MASK) != 8'd0;
      s1_sec  <= 7'(bcd_decode(seconds_reg & SEC_MASK));
      s1_min  <= 7'(bcd_decode(minutes_reg & MIN_MASK));
      s1_hour <= 6'(bcd_decode(hours_reg & HOUR_MASK));
      s1_day  <= 6'(bcd_decode(date_reg & DATE_MASK));
      s1_mon  <= 5'(bcd_decode(month_reg & MONTH_MASK));
      s1_yr   <= bcd_decode(year_reg);
    end
  end

  // stage 2: fat words, year day product, month offset, time of day
  logic [4:0]  fh, fs, fd;
  logic [5:0]  fm;
  logic [4:0]  fmo;
  logic [7:0]  fy_raw;
  logic [6:0]  fy;
  logic [3:0]  em;
  logic [7:0]  ycent, y;
  logic [15:0] fat_time_next, fat_date_next;
  logic [17:0] prod_next, tod_next;

  always_comb begin
    fh = (s1_hour > 6'(FAT_HOUR_MAX)) ? FAT_HOUR_MAX : s1_hour[4:0];
    fm = (s1_min > FAT_MIN_MAX) ? FAT_MIN_MAX[5:0] : s1_min[5:0];
    fs = 5'(((s1_sec > FAT_SEC_MAX) ? FAT_SEC_OVER : s1_sec) >> 1);
    fd = (s1_day > FAT_DAY_MAX) ? FAT_DAY_MAX[4:0] : s1_day[4:0];
    fmo = (s1_mon > FAT_MON_MAX) ? FAT_MON_MAX : s1_mon;
    fy_raw = s1_yr + FAT_YEAR_OFS;
    fy = (s1_yr > FAT_YEAR_MAX - FAT_YEAR_OFS) ? FAT_YEAR_MAX[6:0] : fy_raw[6:0];
    fat_time_next = {fh, fm, fs};
    fat_date_next = {fy, fmo[3:0], fd};
    // epoch month forced into 1..12
    if (s1_mon == 5'd0) begin
      em = 4'd1;
    end else if (s1_mon > FAT_MON_MAX) begin
      em = 4'd12;
    end else begin
      em = s1_mon[3:0];
    end
    ycent = (s1_yr < CENTURY_SPLIT) ? 8'(s1_yr + CENTURY_ADD) : s1_yr;
    // january and february close the previous march based year
    y = (em <= 4'd2) ? 8'(ycent - 8'd1) : ycent;
    prod_next = 18'(18'(y) * DAYS_4Y);
    tod_next = 18'(18'(s1_hour) * SEC_PER_HOUR + 18'(s1_min) * SEC_PER_MIN
                   + 18'(s1_sec));
  end

  logic        s2_halt;
  logic [15:0] s2_fat_time, s2_fat_date;
  logic [17:0] s2_prod, s2_tod;
  mon_ofs_t    s2_mofs;
  logic [5:0]  s2_day;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_halt     <= s1_halt;
      s2_fat_time <= fat_time_next;
      s2_fat_date <= fat_date_next;
      s2_prod     <= prod_next;
      s2_tod      <= tod_next;
      s2_mofs     <= MONTH_OFS[em - 4'd1];
      s2_day      <= s1_day;
    end
  end

  // stage 3: days since the epoch
  logic signed [17:0] dday_next;

  always_comb begin
    dday_next = 18'(signed'({1'b0, s2_day})) - 18'sd1 + 18'(s2_mofs)
                + signed'({2'b0, s2_prod[17:2]}) - DAYS_BASE;
  end

  logic               s3_halt;
  logic [15:0]        s3_fat_time, s3_fat_date;
  logic [17:0]        s3_tod;
  logic signed [17:0] s3_dday;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_halt     <= s2_halt;
      s3_fat_time <= s2_fat_time;
      s3_fat_date <= s2_fat_date;
      s3_tod      <= s2_tod;
      s3_dday     <= dday_next;
    end
  end

  // stage 4: days to seconds
  logic               s4_halt;
  logic [15:0]        s4_fat_time, s4_fat_date;
  logic [17:0]        s4_tod;
  logic signed [33:0] s4_dsec;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_halt     <= s3_halt;
      s4_fat_time <= s3_fat_time;
      s4_fat_date <= s3_fat_date;
      s4_tod      <= s3_tod;
      s4_dsec     <= 34'(s3_dday) * SEC_PER_DAY;
    end
  end

  // stage 5: final add, halted oscillator forces zeros
  logic signed [33:0] secs_next;

  always_comb begin
    secs_next = s4_dsec + signed'({16'b0, s4_tod});
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      status        <= s4_halt;
      fat_time      <= s4_halt ? 16'd0 : s4_fat_time;
      fat_date      <= s4_halt ? 16'd0 : s4_fat_date;
      epoch_seconds <= s4_halt ? '0 : secs_next[32:0];
    end
  end

endmodule

>>> hw/rtl/rtc_bcd_snapshot_to_timestamps.sv
// top level of the bcd rtc snapshot converter: handshake and valid chain
// depends on rbts_pkg, rbts_ifs (rbts_snap_if, rbts_stamp_if), rbts_datapath
//
// snap carries one request: six bcd clock registers read in one go
// (seconds, minutes, hours, date, month, year). stamp returns one result per
// request: status, fat time word, fat date word and signed seconds since 1970.
// bit 7 of seconds marks a halted oscillator: status 1, all other fields zero.
// stamp.valid rises once a request has passed the five stage registers (the
// first of them loads at the edge that accepts the request). one request can
// be accepted every cycle while the receiver takes results, set by the five
// payload registers that each stage owns
// (decode, fat packing, day sum, day multiply, final add).
// each stage holds a valid bit; a stage loads when it is empty or when the
// stage after it moves, so a stalled receiver fills the pipe up to five
// results before snap.ready drops, and nothing is lost or repeated.
// rst (synchronous, active high) empties the pipe; payload registers are not
// cleared, and stamp.valid is low from the cycle after reset.
module rtc_bcd_snapshot_to_timestamps (
  input logic          clk,
  input logic          rst,
  rbts_snap_if.sink    snap,
  rbts_stamp_if.source stamp
);
  import rbts_pkg::*;

  logic [NSTAGE-1:0] vld;
  stage_en_t         en;

  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || stamp.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= snap.valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign snap.ready  = en[0];
  assign stamp.valid = vld[NSTAGE-1];

  rbts_datapath u_dp (
    .clk           (clk),
    .en            (en),
    .seconds_reg   (snap.seconds_reg),
    .minutes_reg   (snap.minutes_reg),
    .hours_reg     (snap.hours_reg),
    .date_reg      (snap.date_reg),
    .month_reg     (snap.month_reg),
    .year_reg      (snap.year_reg),
    .status        (stamp.status),
    .fat_time      (stamp.fat_time),
    .fat_date      (stamp.fat_date),
    .epoch_seconds (stamp.epoch_seconds)
  );

endmodule

>>> test/tb_rtc_bcd_snapshot_to_timestamps.sv
// testbench for rtc_bcd_snapshot_to_timestamps: random and directed clock snapshots,
// each result checked against a local prediction of the status, fat words and epoch seconds
// depends on rbts_pkg, rbts_ifs and the top level of the converter
module tb_rtc_bcd_snapshot_to_timestamps;
  import rbts_pkg::*;

  typedef struct packed {
    logic [7:0] seconds_reg;
    logic [7:0] minutes_reg;
    logic [7:0] hours_reg;
    logic [7:0] date_reg;
    logic [7:0] month_reg;
    logic [7:0] year_reg;
  } snap_t;

  typedef struct packed {
    logic        status;
    logic [15:0] fat_time;
    logic [15:0] fat_date;
    epoch_t      epoch_seconds;
  } stamp_t;

  localparam int N_RANDOM = 1280;
  localparam int N_CALM   = 150;

  localparam snap_t DIRECTED_SNAPS [20] = '{
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    {8'h7f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff},
    {8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    {8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff},
    {8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70},
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h70},
    {8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69},
    {8'h60, 8'h60, 8'h24, 8'h32, 8'h13, 8'h99},
    {8'h58, 8'h59, 8'h23, 8'h31, 8'h12, 8'ha0},
    {8'h0f, 8'h0f, 8'h0f, 8'h0f, 8'h0f, 8'h0f},
    {8'h01, 8'h00, 8'h00, 8'h01, 8'h02, 8'h00},
    {8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00},
    {8'h45, 8'h45, 8'h45, 8'h3f, 8'h1f, 8'h99},
    {8'h00, 8'h80, 8'hc0, 8'hc0, 8'he0, 8'h00},
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h70},
    {8'h30, 8'h30, 8'h12, 8'h15, 8'h06, 8'h24},
    {8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00},
    {8'h29, 8'h14, 8'h07, 8'h28, 8'h02, 8'ha5},
    {8'h61, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70},
    {8'h80, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99}
  };

  class stamp_book;
    stamp_t pending_stamps[$];
    int     mismatches;

    static function longint bcd_value(logic [7:0] b);
      return 10 * longint'(b[7:4]) + longint'(b[3:0]);
    endfunction

    static function stamp_t predict_stamp(snap_t s);
      // march based day offsets, january and february sit at the end
      longint ofs[12] = '{428, 459, 122, 153, 183, 214, 244, 275, 306, 336, 367, 397};
      longint sec, mnt, hr, dy, mo, yr;
      longint fh, fm, fs, fd, fmo, fy, em, y, days, total;
      stamp_t r;
      r = '0;
      if (s.seconds_reg[7]) begin
        r.status = 1'b1;
        return r;
      end
      sec = bcd_value(s.seconds_reg & SEC_MASK);
      mnt = bcd_value(s.minutes_reg & MIN_MASK);
      hr  = bcd_value(s.hours_reg & HOUR_MASK);
      dy  = bcd_value(s.date_reg & DATE_MASK);
      mo  = bcd_value(s.month_reg & MONTH_MASK);
      yr  = bcd_value(s.year_reg);
      fh  = hr > 23 ? 23 : hr;
      fm  = mnt > 59 ? 59 : mnt;
      fs  = (sec > 59 ? 60 : sec) >> 1;
      r.fat_time = 16'((fh & 31) << 11) | 16'((fm & 63) << 5) | 16'(fs & 31);
      fd  = dy > 31 ? 31 : dy;
      fmo = mo > 12 ? 12 : mo;
      fy  = yr + 20 > 119 ? 119 : yr + 20;
      r.fat_date = 16'(fd & 31) | 16'((fmo & 31) << 5) | 16'((fy & 127) << 9);
      em = mo < 1 ? 1 : (mo > 12 ? 12 : mo);
      y  = yr < 70 ? yr + 100 : yr;
      if (em <= 2) y = y - 1;
      days  = (1461 * y) / 4 - (1461 * 69) / 4 + dy - 1 + ofs[em - 1] - ofs[0];
      total = 86400 * days + 60 * (60 * hr + mnt) + sec;
      r.epoch_seconds = total[32:0];
      return r;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void note_request(snap_t s);
      pending_stamps.push_back(predict_stamp(s));
    endfunction

    function void check_stamp(stamp_t got);
      stamp_t want;
      string  bad;
      if (pending_stamps.size() == 0) begin
        flag($sformatf("result with none expected: st=%0d ft=%h fd=%h ep=%0d",
                       got.status, got.fat_time, got.fat_date, got.epoch_seconds));
        return;
      end
      want = pending_stamps.pop_front();
      bad = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.fat_time !== want.fat_time) bad = {bad, " fat_time"};
      if (got.fat_date !== want.fat_date) bad = {bad, " fat_date"};
      if (got.epoch_seconds !== want.epoch_seconds) bad = {bad, " epoch_seconds"};
      if (bad != "")
        flag($sformatf("%s: want st=%0d ft=%h fd=%h ep=%0d, got st=%0d ft=%h fd=%h ep=%0d",
                       bad, want.status, want.fat_time, want.fat_date, want.epoch_seconds,
                       got.status, got.fat_time, got.fat_date, got.epoch_seconds));
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   quiet_tail;

  stamp_book book = new();

  rbts_snap_if  snap_ch ();
  rbts_stamp_if stamp_ch ();

  rtc_bcd_snapshot_to_timestamps dut (
    .clk   (clk),
    .rst   (rst),
    .snap  (snap_ch),
    .stamp (stamp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 400000);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [7:0] to_bcd(int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  task automatic drive_snap(snap_t s, logic v);
    snap_ch.valid       <= v;
    snap_ch.seconds_reg <= s.seconds_reg;
    snap_ch.minutes_reg <= s.minutes_reg;
    snap_ch.hours_reg   <= s.hours_reg;
    snap_ch.date_reg    <= s.date_reg;
    snap_ch.month_reg   <= s.month_reg;
    snap_ch.year_reg    <= s.year_reg;
  endtask

  // random gap before the next request, junk payload while valid is low
  task automatic idle_gap(bit steady);
    int n;
    if (quiet_tail || steady || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 13);
    drive_snap(snap_t'({$urandom, $urandom}), 1'b0);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_snap(snap_t s);
    drive_snap(s, 1'b1);
    @(posedge clk);
    while (snap_ch.ready !== 1'b1) @(posedge clk);
    book.note_request(s);
  endtask

  initial begin : stimulus
    snap_t s;
    bit    steady;
    int    wait_cycles;
    steady = 1'b0;
    quiet_tail = 1'b0;
    rst <= 1'b1;
    drive_snap('0, 1'b0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_SNAPS[i]) begin
      idle_gap(1'b0);
      send_snap(DIRECTED_SNAPS[i]);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 2) == 0);
      if (i == N_RANDOM - N_CALM) quiet_tail = 1'b1;
      case ($urandom_range(0, 99)) inside
        [0:24]: s = snap_t'({$urandom, $urandom});
        [25:32]: begin
          s = snap_t'({$urandom, $urandom});
          s.seconds_reg[7] = 1'b1;
        end
        default: begin
          s = {to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59)),
               to_bcd($urandom_range(0, 23)), to_bcd($urandom_range(1, 31)),
               to_bcd($urandom_range(1, 12)), to_bcd($urandom_range(0, 99))};
          // unused upper bits now and then
          if ($urandom_range(0, 7) == 0) begin
            s.minutes_reg[7]   = 1'($urandom_range(0, 1));
            s.hours_reg[7:6]   = 2'($urandom_range(0, 3));
            s.date_reg[7:6]    = 2'($urandom_range(0, 3));
            s.month_reg[7:5]   = 3'($urandom_range(0, 7));
          end
        end
      endcase
      idle_gap(steady);
      send_snap(s);
    end
    snap_ch.valid <= 1'b0;

    wait_cycles = 0;
    while (book.pending_stamps.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (book.pending_stamps.size() != 0) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      if (book.mismatches == 0)
        $display("DONE: 0 errors");
      else
        $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : result_sink
    int stall_left;
    int cyc;
    bit steady;
    stall_left = 0;
    cyc = 0;
    steady = 1'b0;
    stamp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      cyc++;
      if (cyc % 200 == 0) steady = ($urandom_range(0, 2) == 0);
      if (cyc == 800) begin
        // long hold-off so the pipe fills and snap.ready drops
        stamp_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        stamp_ch.ready <= 1'b0;
      end else if (!steady && !quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        stamp_ch.ready <= 1'b0;
      end else begin
        stamp_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stamp_monitor
    stamp_t got;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && stamp_ch.valid === 1'b1 && stamp_ch.ready === 1'b1) begin
        got.status        = stamp_ch.status;
        got.fat_time      = stamp_ch.fat_time;
        got.fat_date      = stamp_ch.fat_date;
        got.epoch_seconds = stamp_ch.epoch_seconds;
        book.check_stamp(got);
      end
    end
  end

endmodule
